>>> rtl/core/johab_to_ksx1001_decoder_unit_defines.svh
// Assertion macros for the JOHAB decoder
`ifndef JOHAB_TO_KSX1001_DECODER_UNIT_DEFINES_SVH
`define JOHAB_TO_KSX1001_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define J2K_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("j2k assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define J2K_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("j2k assertion failed");

`endif

>>> rtl/core/j2k_pkg.sv
package j2k_pkg;

    // Code size field values
    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_ONE  = 2'd1;
    localparam logic [1:0] SIZE_TWO  = 2'd2;

    // Charset field values
    localparam logic [1:0] CHARSET_ASCII = 2'd0;
    localparam logic [1:0] CHARSET_KSX   = 2'd1;
    localparam logic [1:0] CHARSET_JOHAB = 2'd2;

    // Byte class limits
    localparam logic [7:0] ASCII_MAX     = 8'h7f;
    localparam logic [7:0] KSX_LEAD_LO_A = 8'hd8;
    localparam logic [7:0] KSX_LEAD_HI_A = 8'hde;
    localparam logic [7:0] KSX_LEAD_LO_B = 8'he0;
    localparam logic [7:0] KSX_LEAD_HI_B = 8'hf9;
    localparam logic [7:0] TRAIL_LOW_MAX = 8'ha0;
    localparam logic [7:0] TRAIL_7E      = 8'h7e;

    // Row/cell offsets, all taken modulo 256
    localparam logic [7:0] ROW_D8_LOW    = 8'h49;  // 0x29 + 0x20
    localparam logic [7:0] ROW_D8_HIGH   = 8'h7e;  // 0x5e + 0x20
    localparam logic [7:0] ROW_A_LOW     = 8'h6f;  // 0x20 - 0x1b1
    localparam logic [7:0] ROW_B_LOW     = 8'h8a;  // 0x20 - 0x196
    localparam logic [7:0] ROW_A_HIGH    = 8'h70;  // 0x20 - 0x1b0
    localparam logic [7:0] ROW_B_HIGH    = 8'h8b;  // 0x20 - 0x195
    localparam logic [7:0] CELL_LOW_7E   = 8'hf0;  // 0x100 + 0x20 - 0x30
    localparam logic [7:0] CELL_LOW_A0   = 8'hde;  // 0x20 - 0x42
    localparam logic [7:0] CELL_HIGH     = 8'h80;  // 0x20 - 0xa0

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_data;
    } byte_word_t;

    typedef struct packed {
        logic [7:0] code_first;
        logic [7:0] code_second;
        logic [1:0] code_size;
        logic [1:0] charset;
        logic       truncated;
    } char_word_t;

    function automatic logic is_ksx_lead(input logic [7:0] b);
        is_ksx_lead = ((b >= KSX_LEAD_LO_A) && (b <= KSX_LEAD_HI_A))
                   || ((b >= KSX_LEAD_LO_B) && (b <= KSX_LEAD_HI_B));
    endfunction

    // KS X 1001 row byte from lead and trail
    function automatic logic [7:0] ksx_row(input logic [7:0] b1, input logic [7:0] b2);
        logic [7:0] dbl;
        dbl = {b1[6:0], 1'b0};
        if (b2 <= TRAIL_LOW_MAX)
        begin
            if (b1 == KSX_LEAD_LO_A)
                ksx_row = ROW_D8_LOW;
            else if (b1 <= KSX_LEAD_HI_A)
                ksx_row = dbl + ROW_A_LOW;
            else
                ksx_row = dbl + ROW_B_LOW;
        end
        else
        begin
            if (b1 == KSX_LEAD_LO_A)
                ksx_row = ROW_D8_HIGH;
            else if (b1 <= KSX_LEAD_HI_A)
                ksx_row = dbl + ROW_A_HIGH;
            else
                ksx_row = dbl + ROW_B_HIGH;
        end
    endfunction

    // KS X 1001 cell byte from trail
    function automatic logic [7:0] ksx_cell(input logic [7:0] b2);
        if (b2 <= TRAIL_7E)
            ksx_cell = b2 + CELL_LOW_7E;
        else if (b2 <= TRAIL_LOW_MAX)
            ksx_cell = b2 + CELL_LOW_A0;
        else
            ksx_cell = b2 + CELL_HIGH;
    endfunction

endpackage

>>> rtl/core/johab_to_ksx1001_decoder_unit.sv
// JOHAB to KS X 1001 byte-stream decoder.
// Input channel byte_*: one raw JOHAB byte per word plus an end_of_data flag.
// Output channel char_*: one decoded character per word (ASCII, KS X 1001
// row/cell, raw JOHAB Hangul pair, or a truncated-lead status word).
// A lead byte without end_of_data produces no word; the following trail byte produces the pair.
// Datapath: input register -> combinational mapping -> result register.
// Path: a word's last byte waits in the input register, then the word is
// registered in the result register and shows on char_*, where it can be
// taken; a stall on char_ready can hold a byte in the input register.
// Throughput: one byte per cycle while char_ready is not stalling.
// Stall: while char_ready is low the result register holds its word; the
// input register still drains lead bytes (they give no word), and
// byte_ready drops once a byte that yields a word is waiting behind it.
// Reset: clears both valid flags and the pending-lead flag; no lead byte
// is carried across reset.
`include "johab_to_ksx1001_decoder_unit_defines.svh"

module johab_to_ksx1001_decoder_unit
    import j2k_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_word_t byte_word,
    output logic       char_valid,
    input  logic       char_ready,
    output char_word_t char_word
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    byte_word_t s1_word_reg;
    logic       lead_pending_reg;
    logic       lead_pending_next;
    logic [7:0] lead_value_reg;
    logic       char_valid_reg;
    logic       char_valid_next;
    char_word_t char_word_reg;
    char_word_t char_word_next;

    logic       has_result;
    logic       out_space;
    logic       s1_fire;
    logic       byte_fire;
    logic [7:0] cur_byte;

    // Stage control
    assign cur_byte   = s1_word_reg.in_byte;
    assign has_result = lead_pending_reg || (cur_byte <= ASCII_MAX)
                     || s1_word_reg.end_of_data;
    assign out_space  = !char_valid_reg || char_ready;
    assign s1_fire    = s1_valid_reg && (!has_result || out_space);
    assign byte_ready = !s1_valid_reg || s1_fire;
    assign byte_fire  = byte_valid && byte_ready;

    assign s1_valid_next   = byte_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign char_valid_next = (s1_fire && has_result) ? 1'b1
                           : (char_ready ? 1'b0 : char_valid_reg);

    // Pending-lead update
    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        if (s1_fire)
            lead_pending_next = !lead_pending_reg && (cur_byte > ASCII_MAX)
                             && !s1_word_reg.end_of_data;
    end

    // Character mapping
    always_comb
    begin
        char_word_next = '0;
        if (lead_pending_reg)
        begin
            char_word_next.code_size = SIZE_TWO;
            if (is_ksx_lead(lead_value_reg))
            begin
                char_word_next.code_first  = ksx_row(lead_value_reg, cur_byte);
                char_word_next.code_second = ksx_cell(cur_byte);
                char_word_next.charset     = CHARSET_KSX;
            end
            else
            begin
                char_word_next.code_first  = lead_value_reg;
                char_word_next.code_second = cur_byte;
                char_word_next.charset     = CHARSET_JOHAB;
            end
        end
        else if (cur_byte <= ASCII_MAX)
        begin
            char_word_next.code_first = cur_byte;
            char_word_next.code_size  = SIZE_ONE;
            char_word_next.charset    = CHARSET_ASCII;
        end
        else
        begin
            // lead byte at end of data: dropped, status word only
            char_word_next.code_first = cur_byte;
            char_word_next.code_size  = SIZE_NONE;
            char_word_next.charset    = CHARSET_ASCII;
            char_word_next.truncated  = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            lead_pending_reg <= 1'b0;
            char_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            lead_pending_reg <= lead_pending_next;
            char_valid_reg   <= char_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (byte_fire)
            s1_word_reg <= byte_word;
        if (s1_fire && !lead_pending_reg)
            lead_value_reg <= cur_byte;
        if (s1_fire && has_result)
            char_word_reg <= char_word_next;
    end

    assign char_valid = char_valid_reg;
    assign char_word  = char_word_reg;

    // Checks
    `J2K_ASSERT_NEXT(a_pair_clears_lead, s1_fire && lead_pending_reg, !lead_pending_reg)
    `J2K_ASSERT_NEXT(a_lead_only_silent, s1_fire && !has_result, lead_pending_reg)
    `J2K_ASSERT_SAME(a_trunc_form, char_valid_reg && char_word_reg.truncated,
        (char_word_reg.code_size == SIZE_NONE) && (char_word_reg.charset == CHARSET_ASCII))
    `J2K_ASSERT_SAME(a_ascii_form, char_valid_reg && (char_word_reg.code_size == SIZE_ONE),
        (char_word_reg.charset == CHARSET_ASCII) && (char_word_reg.code_second == 8'h00))

endmodule

>>> test/tb_johab_to_ksx1001_decoder_unit.sv
`timescale 1ns / 1ps

module tb_johab_to_ksx1001_decoder_unit;
    import j2k_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake while work is outstanding
    localparam int LONG_HOLD    = 300;   // receiver back-pressure stretch
    localparam int DRAIN_CYCLES = 8;     // result path is two registers deep
    localparam int CHUNK_ITEMS  = 95;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    byte_word_t byte_word = '0;
    logic       char_valid;
    logic       char_ready = 1'b0;
    char_word_t char_word;

    byte_word_t byte_queue[$];
    char_word_t expected_chars[$];

    // decoder state as seen by the predictor
    bit         lead_waiting = 1'b0;
    logic [7:0] lead_byte = '0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    johab_to_ksx1001_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_word  (char_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // expected character for one accepted input byte
    task automatic predict_char(input byte_word_t w);
        char_word_t c;
        int         b1;
        int         b2;
        int         row;
        int         cell_val;
        b2 = int'(w.in_byte);
        c  = '0;
        if (lead_waiting)
        begin
            lead_waiting = 1'b0;
            b1 = int'(lead_byte);
            if ((b1 >= KSX_LEAD_LO_A && b1 <= KSX_LEAD_HI_A) ||
                (b1 >= KSX_LEAD_LO_B && b1 <= KSX_LEAD_HI_B))
            begin
                if (b2 <= TRAIL_LOW_MAX)
                begin
                    if (b1 == KSX_LEAD_LO_A)
                        row = 'h49;
                    else if (b1 <= KSX_LEAD_HI_A)
                        row = b1 * 2 + 'h20 - 'h1b1;
                    else
                        row = b1 * 2 + 'h20 - 'h196;
                    if (b2 <= TRAIL_7E)
                        cell_val = b2 + 'h100 + 'h20 - 'h30;
                    else
                        cell_val = b2 + 'h20 - 'h42;
                end
                else
                begin
                    if (b1 == KSX_LEAD_LO_A)
                        row = 'h7e;
                    else if (b1 <= KSX_LEAD_HI_A)
                        row = b1 * 2 + 'h20 - 'h1b0;
                    else
                        row = b1 * 2 + 'h20 - 'h195;
                    cell_val = b2 + 'h20 - 'ha0;
                end
                c.code_first  = row[7:0];
                c.code_second = cell_val[7:0];
                c.charset     = CHARSET_KSX;
            end
            else
            begin
                c.code_first  = lead_byte;
                c.code_second = w.in_byte;
                c.charset     = CHARSET_JOHAB;
            end
            c.code_size = SIZE_TWO;
            expected_chars.push_back(c);
        end
        else if (w.in_byte <= ASCII_MAX)
        begin
            c.code_first = w.in_byte;
            c.code_size  = SIZE_ONE;
            c.charset    = CHARSET_ASCII;
            expected_chars.push_back(c);
        end
        else if (w.end_of_data)
        begin
            // lead byte cut off by end of data: dropped, status word only
            c.code_first = w.in_byte;
            c.code_size  = SIZE_NONE;
            c.charset    = CHARSET_ASCII;
            c.truncated  = 1'b1;
            expected_chars.push_back(c);
        end
        else
        begin
            lead_waiting = 1'b1;
            lead_byte    = w.in_byte;
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // sender: holds the word until accepted, then pops the next one or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_word  <= '0;
        end
        else
        begin
            if (byte_valid && byte_ready)
                predict_char(byte_word);
            if (!byte_valid || byte_ready)
            begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    byte_valid <= 1'b1;
                    byte_word  <= byte_queue.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each accepted word, stalls at random or for a long hold
    always @(posedge clk or negedge rst_n)
    begin
        char_word_t exp_char;
        if (!rst_n)
            char_ready <= 1'b0;
        else
        begin
            if (char_valid && char_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected word 0x%0h, nothing expected", $time, char_word);
                    error_count++;
                end
                else
                begin
                    exp_char = expected_chars.pop_front();
                    check_field("code_first", int'(exp_char.code_first),
                                int'(char_word.code_first));
                    check_field("code_second", int'(exp_char.code_second),
                                int'(char_word.code_second));
                    check_field("code_size", int'(exp_char.code_size),
                                int'(char_word.code_size));
                    check_field("charset", int'(exp_char.charset),
                                int'(char_word.charset));
                    check_field("truncated", int'(exp_char.truncated),
                                int'(char_word.truncated));
                end
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left = rx_hold_left - 1;
                char_ready <= 1'b0;
            end
            else
                char_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog: no handshake for too long while work is outstanding
    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (char_valid && char_ready))
            quiet_cycles <= 0;
        else if (byte_queue.size() > 0 || byte_valid || expected_chars.size() > 0)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no progress", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic eod);
        byte_word_t w;
        w.in_byte     = b;
        w.end_of_data = eod;
        byte_queue.push_back(w);
    endtask

    // mostly well-formed characters with random content, some raw noise
    task automatic add_random(input int count);
        int         added;
        int         pick;
        logic [7:0] lead;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                add_byte(8'($urandom_range(8'h7f)), $urandom_range(15) == 0);
                added += 1;
            end
            else if (pick < 85)
            begin
                if (pick < 70)
                    lead = $urandom_range(1)
                         ? 8'($urandom_range(KSX_LEAD_HI_A, KSX_LEAD_LO_A))
                         : 8'($urandom_range(KSX_LEAD_HI_B, KSX_LEAD_LO_B));
                else
                begin
                    case ($urandom_range(2))
                        0:       lead = 8'($urandom_range(8'hd7, 8'h80));
                        1:       lead = 8'hdf;
                        default: lead = 8'($urandom_range(8'hff, 8'hfa));
                    endcase
                end
                add_byte(lead, 1'b0);
                add_byte(8'($urandom_range(8'hff)), $urandom_range(7) == 0);
                added += 2;
            end
            else if (pick < 92)
            begin
                add_byte(8'($urandom_range(8'hff, 8'h80)), 1'b1);
                added += 1;
            end
            else
            begin
                add_byte(8'($urandom_range(8'hff)), 1'($urandom_range(1)));
                added += 1;
            end
        end
    endtask

    task automatic wait_drained();
        while (byte_queue.size() > 0 || byte_valid || expected_chars.size() > 0)
            @(negedge clk);
    endtask

    // stimulus sequencing; queue and knobs change on the falling edge only
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes and every mapping branch except a D9-DE lead with a trail above A0
        add_byte(8'h00, 1'b0);
        add_byte(8'h7f, 1'b0);
        add_byte(8'h80, 1'b0); add_byte(8'h00, 1'b0);  // raw Hangul pair
        add_byte(8'hd8, 1'b0); add_byte(8'h41, 1'b0);  // D8 lead, low trail
        add_byte(8'hd8, 1'b0); add_byte(8'ha1, 1'b0);  // D8 lead, high trail
        add_byte(8'hde, 1'b0); add_byte(8'h7e, 1'b0);
        add_byte(8'hde, 1'b0); add_byte(8'ha0, 1'b0);
        add_byte(8'hdf, 1'b0); add_byte(8'hff, 1'b0);  // gap lead, passed raw
        add_byte(8'he0, 1'b0); add_byte(8'h31, 1'b0);
        add_byte(8'hf9, 1'b0); add_byte(8'hfe, 1'b0);
        add_byte(8'hfa, 1'b0); add_byte(8'h7f, 1'b0);
        add_byte(8'hff, 1'b0); add_byte(8'hff, 1'b1);  // trail carries end of data
        add_byte(8'he5, 1'b1);                         // lead cut off by end of data
        add_byte(8'h41, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                // long back-pressure while the sender keeps offering
                if (phase == 0 && chunk == 1)
                    rx_hold_left = LONG_HOLD;
                add_random(CHUNK_ITEMS);
                wait_drained();
            end
        end

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_chars.size() > 0)
            error_count++;
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
